@@ hdl/sm4_pkg.sv @@
// SM4 package: S-box table, FK/CK constants, round transforms, FSM and
// controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package sm4_pkg;

  localparam int ROUNDS_DEF = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int WORD_W     = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = CFG_IDX_W'(1);

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef enum logic [2:0] {
    ST_KLOAD,
    ST_KEXP,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_blk;   // load the accepted block into the word queue
    logic load_key;   // load key ^ FK into the word queue
    logic step;       // advance one round
    logic key_sched;  // round runs the key schedule (else the cipher)
    logic decrypt;    // read round keys in reverse order
    logic capture;    // move the finished block to the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rekey;      // key register written this cycle
    logic out_free;   // output register can take a block this cycle
  } sts_t;

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] l_data(input logic [31:0] t);
    return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
  endfunction

  function automatic logic [31:0] l_key(input logic [31:0] t);
    return t ^ rotl(t, 13) ^ rotl(t, 23);
  endfunction

  // CK constant: byte j of entry i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] ck_const(input logic [7:0] i);
    logic [31:0] v;
    logic [9:0]  p;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      p = ({2'b00, i} << 2) + 10'(j);
      v = {v[23:0], 8'(p * 10'd7)};
    end
    return v;
  endfunction

endpackage

@@ hdl/sm4_if.sv @@
// SM4 channel interfaces: input item, result item and configuration write.
// Depends on sm4_pkg for the register index width.
`timescale 1ns / 1ps

interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, mode, block_hi, block_lo, input ready);
  modport sink   (input valid, mode, block_hi, block_lo, output ready);
endinterface

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface sm4_cfg_if import sm4_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sm4_block_cipher_core.sv @@
// SM4 core: the single shared round unit does one round per cycle for 32 rounds, after a load
// and before a capture; a new item is taken only once the last one is in the output register.
// Key expansion runs after reset and after each key write; the input channel is not ready
// meanwhile. Reset (rst, synchronous) clears the key to zero and expands it. The output
// register lets a result wait while the next item runs.
`timescale 1ns / 1ps

module sm4_block_cipher_core import sm4_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input logic       clk,
  input logic       rst,
  sm4_in_if.sink    block_in,
  sm4_out_if.source result_out,
  sm4_cfg_if.sink   cfg
);

  localparam int CW = $clog2(ROUNDS);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] rnd;

  // Key writes are always taken; a write to a key register restarts expansion
  assign cfg.ready = 1'b1;

  // Controller: walks key load, key expansion, idle, cipher rounds and capture
  sm4_ctrl #(
    .ROUNDS (ROUNDS),
    .CW     (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (block_in.valid),
    .in_mode  (block_in.mode),
    .in_ready (block_in.ready),
    .sts      (sts),
    .cmd      (cmd),
    .rnd      (rnd)
  );

  // Datapath: key registers, round keys, round unit and result register
  sm4_dp #(
    .ROUNDS (ROUNDS),
    .CW     (CW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rnd       (rnd),
    .sts       (sts),
    .block_hi  (block_in.block_hi),
    .block_lo  (block_in.block_lo),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .result_hi (result_out.result_hi),
    .result_lo (result_out.result_lo)
  );

endmodule

@@ hdl/sm4_ctrl.sv @@
// SM4 controller: sequences key expansion, cipher rounds and result capture.
// Depends on sm4_pkg (state_t, cmd_t, sts_t).
`timescale 1ns / 1ps

module sm4_ctrl import sm4_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int CW     = $clog2(ROUNDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_mode,
  output logic          in_ready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [CW-1:0] rnd
);

  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          decrypt, decrypt_next;
  logic          accept;

  assign accept = in_valid && in_ready;
  assign rnd    = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_KLOAD;
      cnt     <= '0;
      decrypt <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      decrypt <= decrypt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    decrypt_next = decrypt;
    cmd          = '0;
    cmd.decrypt  = decrypt;
    in_ready     = 1'b0;
    unique case (state)
      ST_KLOAD: begin
        cmd.load_key = 1'b1;
        cnt_next     = '0;
        state_next   = ST_KEXP;
      end
      ST_KEXP: begin
        cmd.step      = 1'b1;
        cmd.key_sched = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.load_blk = 1'b1;
          decrypt_next = in_mode;
          cnt_next     = '0;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_KLOAD;
      end
    endcase
    // A key write restarts the schedule from the new key
    if (sts.rekey) begin
      state_next = ST_KLOAD;
    end
  end

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && !sts.rekey) |=> (state == ST_RUN && cnt == '0))
    else $error("accepted item did not start at round zero");

  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> sts.out_free)
    else $error("capture into an occupied output register");

  a_rekey_restart: assert property (@(posedge clk) disable iff (rst)
    sts.rekey |=> (state == ST_KLOAD && !in_ready))
    else $error("key write did not restart the key schedule");

endmodule

@@ hdl/sm4_dp.sv @@
// SM4 datapath: key registers, round-key store, shared round unit and
// output register. Depends on sm4_pkg (transforms, constants, cmd_t, sts_t).
`timescale 1ns / 1ps

module sm4_dp import sm4_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int CW     = $clog2(ROUNDS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [CW-1:0]        rnd,
  output sts_t                 sts,
  input  logic [63:0]          block_hi,
  input  logic [63:0]          block_lo,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          result_hi,
  output logic [63:0]          result_lo
);

  logic [63:0]       key_hi, key_lo;
  logic [31:0]       rk [ROUNDS];
  logic [31:0]       w [4];
  logic [CW-1:0]     kidx;
  logic [31:0]       rkey, x, t, f;

  assign sts.rekey    = cfg_we && (cfg_index == CFG_KEY_HI || cfg_index == CFG_KEY_LO);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_HI) begin
        key_hi <= cfg_data;
      end
      if (cfg_index == CFG_KEY_LO) begin
        key_lo <= cfg_data;
      end
    end
  end

  // Round unit: one round of either the key schedule or the cipher
  assign kidx = cmd.decrypt ? CW'(ROUNDS - 1) - rnd : rnd;
  assign rkey = cmd.key_sched ? ck_const(8'(rnd)) : rk[kidx];
  assign x    = w[1] ^ w[2] ^ w[3] ^ rkey;
  assign t    = sub_word(x);
  assign f    = w[0] ^ (cmd.key_sched ? l_key(t) : l_data(t));

  // Word queue: oldest word in w[0], newest round output enters at w[3]
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      w[0] <= key_hi[63:32] ^ FK0;
      w[1] <= key_hi[31:0]  ^ FK1;
      w[2] <= key_lo[63:32] ^ FK2;
      w[3] <= key_lo[31:0]  ^ FK3;
    end else if (cmd.load_blk) begin
      w[0] <= block_hi[63:32];
      w[1] <= block_hi[31:0];
      w[2] <= block_lo[63:32];
      w[3] <= block_lo[31:0];
    end else if (cmd.step) begin
      w[0] <= w[1];
      w[1] <= w[2];
      w[2] <= w[3];
      w[3] <= f;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && cmd.key_sched) begin
      rk[rnd] <= f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Final words go out in reversed order
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      result_hi <= {w[3], w[2]};
      result_lo <= {w[1], w[0]};
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for sm4_block_cipher_core: an in-bench SM4 model predicts every block.
// Depends on sm4_pkg (S-box, FK constants, register indexes) and the channel interfaces.
`timescale 1ns / 1ps

module tb import sm4_pkg::*; ;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

  // Generous bound on the slowest correct run: roughly 1400 items, each with its core time,
  // the longest idle gap and the longest result stall, plus the key expansions.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 160;
  localparam int TAIL_CYCLES  = 40;

  // Predicts the cipher output from its own copy of the key and round keys,
  // and holds the outputs still owed by the core, oldest first.
  class cipher_scoreboard;
    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic [31:0]  round_key[ROUNDS_DEF];
    logic [127:0] expected_blocks[$];
    int           errors;

    function new();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
      expand_key_schedule();
    endfunction

    function logic [31:0] rol(input logic [31:0] x, input int n);
      logic [63:0] twice;
      twice = {x, x};
      return twice[63 - n -: 32];
    endfunction

    function logic [31:0] sbox_word(input logic [31:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function logic [31:0] data_mix(input logic [31:0] x);
      logic [31:0] s;
      s = sbox_word(x);
      return s ^ rol(s, 2) ^ rol(s, 10) ^ rol(s, 18) ^ rol(s, 24);
    endfunction

    function logic [31:0] key_mix(input logic [31:0] x);
      logic [31:0] s;
      s = sbox_word(x);
      return s ^ rol(s, 13) ^ rol(s, 23);
    endfunction

    // Byte j of the round constant i is (4*i + j) * 7, modulo 256.
    function logic [31:0] round_const(input int i);
      logic [31:0] v;
      v = '0;
      for (int j = 0; j < 4; j++) v = {v[23:0], 8'((4 * i + j) * 7)};
      return v;
    endfunction

    function void expand_key_schedule();
      logic [31:0] k[4];
      k[0] = key_hi[63:32] ^ FK0;
      k[1] = key_hi[31:0]  ^ FK1;
      k[2] = key_lo[63:32] ^ FK2;
      k[3] = key_lo[31:0]  ^ FK3;
      for (int i = 0; i < ROUNDS_DEF; i++) begin
        k[i % 4] ^= key_mix(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ round_const(i));
        round_key[i] = k[i % 4];
      end
    endfunction

    // Returns {result_hi, result_lo} for one block under the current key.
    function logic [127:0] cipher_block(input logic mode, input logic [63:0] hi,
                                        input logic [63:0] lo);
      logic [31:0] w[4];
      int          ki;
      w[0] = hi[63:32];
      w[1] = hi[31:0];
      w[2] = lo[63:32];
      w[3] = lo[31:0];
      for (int i = 0; i < ROUNDS_DEF; i++) begin
        ki = (mode == MODE_DEC) ? ROUNDS_DEF - 1 - i : i;
        w[i % 4] ^= data_mix(w[(i + 1) % 4] ^ w[(i + 2) % 4] ^ w[(i + 3) % 4] ^ round_key[ki]);
      end
      return {w[3], w[2], w[1], w[0]};
    endfunction

    // Indexes outside the key registers leave the schedule untouched.
    function void write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
      if (idx == CFG_KEY_HI) key_hi = value;
      else if (idx == CFG_KEY_LO) key_lo = value;
      else return;
      expand_key_schedule();
    endfunction

    function void note_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo);
      expected_blocks.push_back(cipher_block(mode, hi, lo));
    endfunction

    function void check_result(input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] want;
      if (expected_blocks.size() == 0) begin
        $error("result with no block outstanding: result_hi %h result_lo %h", hi, lo);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (hi !== want[127:64]) begin
        $error("result_hi mismatch: expected %h, actual %h", want[127:64], hi);
        errors++;
      end
      if (lo !== want[63:0]) begin
        $error("result_lo mismatch: expected %h, actual %h", want[63:0], lo);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sm4_in_if  in_if();
  sm4_out_if out_if();
  sm4_cfg_if cfg_if();

  cipher_scoreboard sb;

  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  sm4_block_cipher_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .block_in   (in_if),
    .result_out (out_if),
    .cfg        (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count cycles and give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Watch all three channels at each edge. Values read here are the ones from before
  // the edge, so key writes, accepted blocks and results are seen exactly as the core
  // sees them. Key writes come only while idle, so their order against blocks is fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_key(cfg_if.index, cfg_if.data);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_block(in_if.mode, in_if.block_hi, in_if.block_lo);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.result_hi, out_if.result_lo);
      end
    end
  end

  // Result side: with the chance set by recv_stall_pct, drop ready, then hold it high again.
  initial begin
    forever begin
      if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Offer one block and hold it until the core takes it. Valid stays high on return,
  // so back-to-back items go out without a gap; the next call decides on idling.
  task automatic send_block(input logic mode, input logic [63:0] hi, input logic [63:0] lo);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= mode;
    in_if.block_hi <= hi;
    in_if.block_lo <= lo;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Write one configuration register; for a key register the core rebuilds its schedule and blocks input meanwhile.
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and hold off until every outstanding result has come back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Run a block in the given mode, then feed its output back the other way.
  task automatic send_round_trip(input logic mode, input logic [63:0] hi,
                                 input logic [63:0] lo);
    logic [127:0] out;
    out = sb.cipher_block(mode, hi, lo);
    send_block(mode, hi, lo);
    send_block(~mode, out[127:64], out[63:0]);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'(1) << $urandom_range(0, 63);
      3:       return ~(64'(1) << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] rand_bad_index();
    return CFG_IDX_W'($urandom_range(int'(CFG_KEY_LO) + 1, int'(CFG_IDX_MAX)));
  endfunction

  initial begin
    logic        mode;
    logic [63:0] hi;
    logic [63:0] lo;
    int          sent;

    sb = new();
    rst             <= 1'b1;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_ENC;
    in_if.block_hi  <= '0;
    in_if.block_lo  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_KEY_HI;
    cfg_if.data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset key (all zero) first: extremes of the block both ways.
    send_block(MODE_ENC, '0, '0);
    send_block(MODE_ENC, '1, '1);
    send_block(MODE_DEC, '0, '0);
    send_block(MODE_DEC, '1, '1);
    drain_results();

    // Standard known-answer key and block, the matching decryption, then the block extremes.
    write_key_reg(CFG_KEY_HI, 64'h0123456789abcdef);
    write_key_reg(CFG_KEY_LO, 64'hfedcba9876543210);
    send_block(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(MODE_DEC, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
    send_block(MODE_ENC, '0, '0);
    send_block(MODE_DEC, '1, '1);
    drain_results();

    // Write to an index past the key registers: the key must stay as it was.
    write_key_reg(CFG_IDX_MAX, {$urandom, $urandom});
    send_block(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_results();

    // All-ones key.
    write_key_reg(CFG_KEY_HI, '1);
    write_key_reg(CFG_KEY_LO, '1);
    send_block(MODE_ENC, '0, '0);
    send_block(MODE_ENC, '1, '1);
    send_block(MODE_DEC, '0, '0);
    send_block(MODE_DEC, '1, '1);
    drain_results();

    // Update one half only: the schedule is rebuilt from both registers.
    write_key_reg(CFG_KEY_LO, '0);
    send_block(MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(MODE_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain_results();

    // Random part, one key per phase; the last phase runs with no random idle gaps or result stalls.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_key_reg(CFG_KEY_HI, '0);
          write_key_reg(CFG_KEY_LO, '0);
        end
        1: begin
          write_key_reg(CFG_KEY_HI, '1);
          write_key_reg(CFG_KEY_LO, '1);
        end
        default: begin
          if ($urandom_range(0, 2) != 0) write_key_reg(CFG_KEY_HI, rand_half());
          if ($urandom_range(0, 2) != 0) write_key_reg(CFG_KEY_LO, rand_half());
        end
      endcase
      if ($urandom_range(0, 2) == 0) write_key_reg(rand_bad_index(), {$urandom, $urandom});

      if (phase == PHASES - 1) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = pick_pct();
        recv_stall_pct = pick_pct();
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode = 1'($urandom_range(0, 1));
        hi   = rand_half();
        lo   = rand_half();
        if ($urandom_range(0, 3) == 0) begin
          send_round_trip(mode, hi, lo);
          sent += 2;
        end else begin
          send_block(mode, hi, lo);
          sent++;
        end
        // Now and then hold the sender until the core has emptied out.
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/sm4_pkg.sv
hdl/sm4_if.sv
hdl/sm4_ctrl.sv
hdl/sm4_dp.sv
hdl/sm4_block_cipher_core.sv
bench/tb.sv
